// ===== rtl/cyc_pkg.sv =====
`timescale 1ns / 1ps

package cyc_pkg;

    // Operation codes carried by the input word.
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_PAUSE  = 2'd1;
    localparam logic [1:0] OP_RESUME = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CYCLE_NS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LOG_SEC  = 2'd1;

    // Register reset values.
    localparam logic [31:0] MAX_CYCLE_RESET = 32'd20000000;
    localparam logic [15:0] MIN_LOG_RESET   = 16'd60;

    // Time arithmetic constants.
    localparam logic [29:0] NS_PER_SEC    = 30'd1000000000;
    localparam logic [29:0] NSEC_MAX      = 30'd999999999;
    localparam logic [31:0] GAP_CLAMP_NS  = 32'd4000000000;
    localparam logic [33:0] GAP_CLAMP_SEC = 34'd4;

    // One input word as held in the input register.
    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] stamp_sec;
        logic [29:0] stamp_nsec;
    } cyc_item_t;

    // Differences between a sample and the stored timestamp.
    typedef struct packed {
        logic [33:0] dsec;
        logic [29:0] dnsec;
        logic [31:0] gap_ns;
    } cyc_delta_t;

    // One result word.
    typedef struct packed {
        logic        underrun;
        logic        logged;
        logic [31:0] gap_ns;
        logic [31:0] underrun_total;
        logic [31:0] log_total;
    } cyc_result_t;

    // Configuration as seen by the state logic.
    typedef struct packed {
        logic [31:0] max_cycle_ns;
        logic [15:0] min_log_interval_sec;
    } cyc_cfg_t;

endpackage

// ===== rtl/cycle_overrun_monitor.sv =====
`timescale 1ns / 1ps

// Cycle overrun monitor. Each input word is a monotonic timestamp sample, a pause
// or a resume, and each gives exactly one result word. The block accepts one word
// per clock cycle, and its result word is formed as follows: the word
// is held in an input register, the gap, log timer and counters are worked out in a
// single pass from there into the result register when it advances, and the monitor
// state updates on that same edge. While both registers hold words, s_ready follows
// m_ready, so throughput stays at one word per cycle as long as the downstream side
// takes results. Configuration writes take effect on the next edge and should only
// be made while no words are in flight.
module cycle_overrun_monitor
    import cyc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_operation,
    input  logic [31:0]          s_stamp_sec,
    input  logic [29:0]          s_stamp_nsec,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_underrun,
    output logic                 m_logged,
    output logic [31:0]          m_gap_ns,
    output logic [31:0]          m_underrun_total,
    output logic [31:0]          m_log_total
);

    cyc_cfg_t    cfg_reg;
    logic        in_valid_reg;
    cyc_item_t   in_item_reg, in_item_next;
    logic        out_valid_reg;
    cyc_result_t out_result_reg;
    cyc_result_t result;
    logic        advance;
    logic        step_en;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_cycle_ns         <= MAX_CYCLE_RESET;
            cfg_reg.min_log_interval_sec <= MIN_LOG_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MAX_CYCLE_NS: cfg_reg.max_cycle_ns         <= cfg_data;
                REG_MIN_LOG_SEC:  cfg_reg.min_log_interval_sec <= cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // The result register moves on when it is empty or being taken.
    assign advance = !out_valid_reg || m_ready;
    assign step_en = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    // Input word, with the nanoseconds saturated on the way in.
    always_comb begin
        in_item_next.operation  = s_operation;
        in_item_next.stamp_sec  = s_stamp_sec;
        in_item_next.stamp_nsec = (s_stamp_nsec > NSEC_MAX) ? NSEC_MAX : s_stamp_nsec;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= in_item_next;
        end
    end

    cyc_state u_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_result_reg <= result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_underrun       = out_result_reg.underrun;
    assign m_logged         = out_result_reg.logged;
    assign m_gap_ns         = out_result_reg.gap_ns;
    assign m_underrun_total = out_result_reg.underrun_total;
    assign m_log_total      = out_result_reg.log_total;

endmodule

// ===== rtl/cyc_gap_calc.sv =====
`timescale 1ns / 1ps

module cyc_gap_calc
    import cyc_pkg::*;
(
    input  logic [31:0] stamp_sec,
    input  logic [29:0] stamp_nsec,
    input  logic [31:0] prev_sec,
    input  logic [29:0] prev_nsec,
    output cyc_delta_t  delta
);

    logic [30:0] dnsec_raw;
    logic        borrow;
    logic [30:0] dnsec_fix;
    logic [33:0] dsec;
    logic [29:0] dnsec;
    logic        dsec_pos;
    logic        dsec_small;
    logic [31:0] gap_sum;
    logic [31:0] gap_ns;

    // Nanosecond difference with a borrow from the seconds.
    assign dnsec_raw = {1'b0, stamp_nsec} - {1'b0, prev_nsec};
    assign borrow    = dnsec_raw[30];
    assign dnsec_fix = dnsec_raw + {1'b0, NS_PER_SEC};

    // Seconds difference, two's complement over 34 bits.
    assign dsec  = {2'b00, stamp_sec} - {2'b00, prev_sec} - {33'd0, borrow};
    assign dnsec = borrow ? dnsec_fix[29:0] : dnsec_raw[29:0];

    // The gap is clamped at four seconds; a backward step keeps only the nanoseconds.
    assign dsec_pos   = !dsec[33] && (dsec != 34'd0);
    assign dsec_small = dsec < GAP_CLAMP_SEC;
    assign gap_sum    = {2'b00, dnsec}
                        + (32'(dsec[1:0]) * {2'b00, NS_PER_SEC});

    always_comb begin
        if (!dsec_pos) begin
            gap_ns = {2'b00, dnsec};
        end else if (dsec_small) begin
            gap_ns = gap_sum;
        end else begin
            gap_ns = GAP_CLAMP_NS;
        end
    end

    assign delta = {dsec, dnsec, gap_ns};

endmodule

// ===== rtl/cyc_state.sv =====
`timescale 1ns / 1ps

module cyc_state
    import cyc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step_en,
    input  cyc_item_t   item,
    input  cyc_cfg_t    cfg,
    output cyc_result_t result
);

    logic        prev_valid_reg, prev_valid_next;
    logic [31:0] prev_sec_reg, prev_sec_next;
    logic [29:0] prev_nsec_reg, prev_nsec_next;
    logic [31:0] timer_sec_reg, timer_sec_next;
    logic [29:0] timer_nsec_reg, timer_nsec_next;
    logic [31:0] under_cnt_reg, under_cnt_next;
    logic [31:0] log_cnt_reg, log_cnt_next;
    logic        paused_reg, paused_next;

    cyc_delta_t  delta;
    logic [30:0] tnsec_sum;
    logic        tnsec_carry;
    logic [30:0] tnsec_wrap;
    logic [34:0] tsec_sum;
    logic [31:0] tsec_sat;
    logic [29:0] tnsec_new;

    cyc_gap_calc u_gap_calc (
        .stamp_sec  (item.stamp_sec),
        .stamp_nsec (item.stamp_nsec),
        .prev_sec   (prev_sec_reg),
        .prev_nsec  (prev_nsec_reg),
        .delta      (delta)
    );

    // Log timer advance with a nanosecond carry and saturation of the seconds.
    assign tnsec_sum   = {1'b0, timer_nsec_reg} + {1'b0, delta.dnsec};
    assign tnsec_carry = tnsec_sum >= {1'b0, NS_PER_SEC};
    assign tnsec_wrap  = tnsec_sum - {1'b0, NS_PER_SEC};
    assign tnsec_new   = tnsec_carry ? tnsec_wrap[29:0] : tnsec_sum[29:0];
    assign tsec_sum    = {3'b000, timer_sec_reg} + {delta.dsec[33], delta.dsec}
                         + {34'd0, tnsec_carry};

    always_comb begin
        if (tsec_sum[34]) begin
            tsec_sat = 32'd0;
        end else if (tsec_sum[33:32] != 2'b00) begin
            tsec_sat = 32'hFFFF_FFFF;
        end else begin
            tsec_sat = tsec_sum[31:0];
        end
    end

    // Next state and result for the word in the input register.
    always_comb begin
        prev_valid_next = prev_valid_reg;
        prev_sec_next   = prev_sec_reg;
        prev_nsec_next  = prev_nsec_reg;
        timer_sec_next  = timer_sec_reg;
        timer_nsec_next = timer_nsec_reg;
        under_cnt_next  = under_cnt_reg;
        log_cnt_next    = log_cnt_reg;
        paused_next     = paused_reg;
        result.underrun = 1'b0;
        result.logged   = 1'b0;
        result.gap_ns   = 32'd0;

        if (step_en) begin
            case (item.operation)
                OP_PAUSE: begin
                    paused_next = 1'b1;
                end
                OP_RESUME: begin
                    if (paused_reg) begin
                        paused_next     = 1'b0;
                        prev_valid_next = 1'b0;
                        timer_sec_next  = {16'd0, cfg.min_log_interval_sec};
                        timer_nsec_next = 30'd0;
                    end
                end
                OP_SAMPLE: begin
                    if (!paused_reg) begin
                        prev_valid_next = 1'b1;
                        prev_sec_next   = item.stamp_sec;
                        prev_nsec_next  = item.stamp_nsec;
                        if (prev_valid_reg) begin
                            timer_sec_next  = tsec_sat;
                            timer_nsec_next = tnsec_new;
                            result.gap_ns   = delta.gap_ns;
                            if (delta.gap_ns > cfg.max_cycle_ns) begin
                                result.underrun = 1'b1;
                                under_cnt_next  = under_cnt_reg + 32'd1;
                                if (tsec_sat >= {16'd0, cfg.min_log_interval_sec}) begin
                                    result.logged   = 1'b1;
                                    log_cnt_next    = log_cnt_reg + 32'd1;
                                    timer_sec_next  = 32'd0;
                                    timer_nsec_next = 30'd0;
                                end
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        result.underrun_total = under_cnt_next;
        result.log_total      = log_cnt_next;
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_valid_reg <= 1'b0;
            prev_sec_reg   <= 32'd0;
            prev_nsec_reg  <= 30'd0;
            timer_sec_reg  <= {16'd0, MIN_LOG_RESET};
            timer_nsec_reg <= 30'd0;
            under_cnt_reg  <= 32'd0;
            log_cnt_reg    <= 32'd0;
            paused_reg     <= 1'b0;
        end else begin
            prev_valid_reg <= prev_valid_next;
            prev_sec_reg   <= prev_sec_next;
            prev_nsec_reg  <= prev_nsec_next;
            timer_sec_reg  <= timer_sec_next;
            timer_nsec_reg <= timer_nsec_next;
            under_cnt_reg  <= under_cnt_next;
            log_cnt_reg    <= log_cnt_next;
            paused_reg     <= paused_next;
        end
    end

endmodule

// ===== rtl/cyc_checker.sv =====
`timescale 1ns / 1ps

module cyc_checker
    import cyc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_underrun,
    input logic        m_logged,
    input logic [31:0] m_gap_ns,
    input logic [31:0] m_underrun_total,
    input logic [31:0] m_log_total
);

    // Only an underrun can be logged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_logged || m_underrun))
        else $error("logged result without underrun");

    // The reported gap never exceeds the clamp.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_gap_ns <= GAP_CLAMP_NS))
        else $error("gap above clamp");

    // A zero gap can never exceed any maximum.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_gap_ns == 32'd0)) |-> !m_underrun)
        else $error("underrun reported with zero gap");

    // A stalled result word holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_gap_ns) && $stable(m_underrun)
            && $stable(m_logged) && $stable(m_underrun_total) && $stable(m_log_total)))
        else $error("stalled result word changed");

endmodule

bind cycle_overrun_monitor cyc_checker u_cyc_checker (.*);

// ===== tb/sv/tb_cycle_overrun_monitor.sv =====
`timescale 1ns / 1ps

module tb_cycle_overrun_monitor;
    import cyc_pkg::*;

    // Codes the package leaves unnamed.
    localparam logic [1:0]           OP_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // Time arithmetic for the gap predictor, in signed 64-bit terms.
    localparam longint NS_ONE_SEC    = 64'sd1000000000;
    localparam longint GAP_CAP_NS    = 64'sd4000000000;
    localparam longint GAP_CAP_SEC   = 64'sd4;
    localparam longint TIMER_SEC_TOP = 64'sd4294967295;

    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_HOLD     = 300;
    localparam int CYCLE_LIMIT   = 400000;

    logic                 aclk             = 1'b0;
    logic                 aresetn          = 1'b0;
    logic                 cfg_wr_en        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index        = '0;
    logic [31:0]          cfg_data         = '0;
    logic                 s_valid          = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_operation      = OP_SAMPLE;
    logic [31:0]          s_stamp_sec      = '0;
    logic [29:0]          s_stamp_nsec     = '0;
    logic                 m_valid;
    logic                 m_ready          = 1'b0;
    logic                 m_underrun;
    logic                 m_logged;
    logic [31:0]          m_gap_ns;
    logic [31:0]          m_underrun_total;
    logic [31:0]          m_log_total;

    cycle_overrun_monitor u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_stamp_sec      (s_stamp_sec),
        .s_stamp_nsec     (s_stamp_nsec),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_underrun       (m_underrun),
        .m_logged         (m_logged),
        .m_gap_ns         (m_gap_ns),
        .m_underrun_total (m_underrun_total),
        .m_log_total      (m_log_total)
    );

    always #10 aclk = ~aclk;

    // One row of the directed table.
    typedef struct {
        logic [1:0]  op;
        logic [31:0] sec;
        logic [29:0] nsec;
        bit          known;
        cyc_result_t want;
    } directed_row_t;

    directed_row_t directed_rows[$];
    cyc_result_t   expected_results[$];

    // Predictor copy of the configuration and the monitor state.
    logic [31:0] cfg_max_cycle_ns;
    logic [15:0] cfg_min_log_sec;
    logic        mon_prev_valid;
    logic [31:0] mon_prev_sec;
    logic [29:0] mon_prev_nsec;
    logic [31:0] mon_timer_sec;
    logic [29:0] mon_timer_nsec;
    logic [31:0] mon_underruns;
    logic [31:0] mon_logs;
    logic        mon_paused;

    // Where the stimulus thinks the timestamp stream currently stands.
    logic [31:0] stream_sec    = '0;
    logic [29:0] stream_nsec   = '0;
    bit          stream_paused = 1'b0;

    bit no_idle      = 1'b0;
    bit hold_request = 1'b0;

    int error_count    = 0;
    int cycle_count    = 0;
    int words_sent     = 0;
    int results_seen   = 0;
    int underruns_seen = 0;
    int logs_seen      = 0;
    int config_writes  = 0;

    // Works out the result word for one accepted input word and moves the state on.
    function automatic cyc_result_t predict_monitor(input logic [1:0]  op,
                                                    input logic [31:0] sec_in,
                                                    input logic [29:0] nsec_raw);
        cyc_result_t res;
        logic [29:0] nsec_in;
        longint      dsec;
        longint      dnsec;
        longint      tsec;
        longint      tnsec;
        longint      gap;
        res = '0;
        case (op)
            OP_PAUSE: mon_paused = 1'b1;
            OP_RESUME: begin
                if (mon_paused) begin
                    mon_paused     = 1'b0;
                    mon_prev_valid = 1'b0;
                    mon_timer_sec  = {16'd0, cfg_min_log_sec};
                    mon_timer_nsec = '0;
                end
            end
            OP_SAMPLE: begin
                if (!mon_paused) begin
                    nsec_in = (nsec_raw > NSEC_MAX) ? NSEC_MAX : nsec_raw;
                    if (!mon_prev_valid) begin
                        // First sample only sets the reference point.
                        mon_prev_valid = 1'b1;
                        mon_prev_sec   = sec_in;
                        mon_prev_nsec  = nsec_in;
                    end else begin
                        dsec  = longint'({32'd0, sec_in}) - longint'({32'd0, mon_prev_sec});
                        dnsec = longint'({34'd0, nsec_in}) - longint'({34'd0, mon_prev_nsec});
                        if (dnsec < 0) begin
                            dsec  = dsec - 1;
                            dnsec = dnsec + NS_ONE_SEC;
                        end
                        mon_prev_sec  = sec_in;
                        mon_prev_nsec = nsec_in;

                        // Going backwards leaves only the borrowed nanoseconds as the gap.
                        gap = dnsec;
                        if (dsec > 0)
                            gap = (dsec < GAP_CAP_SEC) ? dnsec + dsec * NS_ONE_SEC : GAP_CAP_NS;

                        // The log timer takes the unclamped difference and saturates.
                        tsec  = longint'({32'd0, mon_timer_sec}) + dsec;
                        tnsec = longint'({34'd0, mon_timer_nsec}) + dnsec;
                        if (tnsec >= NS_ONE_SEC) begin
                            tsec  = tsec + 1;
                            tnsec = tnsec - NS_ONE_SEC;
                        end
                        if (tsec < 0)
                            tsec = 0;
                        if (tsec > TIMER_SEC_TOP)
                            tsec = TIMER_SEC_TOP;
                        mon_timer_sec  = tsec[31:0];
                        mon_timer_nsec = tnsec[29:0];

                        res.gap_ns = gap[31:0];
                        if (res.gap_ns > cfg_max_cycle_ns) begin
                            res.underrun  = 1'b1;
                            mon_underruns = mon_underruns + 32'd1;
                            if (mon_timer_sec >= {16'd0, cfg_min_log_sec}) begin
                                res.logged     = 1'b1;
                                mon_logs       = mon_logs + 32'd1;
                                mon_timer_sec  = '0;
                                mon_timer_nsec = '0;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        res.underrun_total = mon_underruns;
        res.log_total      = mon_logs;
        return res;
    endfunction

    task automatic add_row(input logic [1:0] op, input logic [31:0] sec,
                           input logic [29:0] nsec, input bit known,
                           input logic u, input logic l, input logic [31:0] gap,
                           input logic [31:0] u_tot, input logic [31:0] l_tot);
        directed_row_t row;
        row.op                  = op;
        row.sec                 = sec;
        row.nsec                = nsec;
        row.known               = known;
        row.want.underrun       = u;
        row.want.logged         = l;
        row.want.gap_ns         = gap;
        row.want.underrun_total = u_tot;
        row.want.log_total      = l_tot;
        directed_rows.push_back(row);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0d, expected %0d (result word %0d)",
                 what, got, want, results_seen);
        error_count++;
    endtask

    // Offers one word, waits for it to be taken and records what it should give.
    task automatic send_word(input logic [1:0] op, input logic [31:0] sec,
                             input logic [29:0] nsec, input bit known,
                             input cyc_result_t want);
        cyc_result_t predicted;
        if (!no_idle && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_operation  <= op;
        s_stamp_sec  <= sec;
        s_stamp_nsec <= nsec;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predicted = predict_monitor(op, sec, nsec);
        expected_results.push_back(known ? want : predicted);
        words_sent++;
        case (op)
            OP_SAMPLE: begin
                stream_sec  = sec;
                stream_nsec = (nsec > NSEC_MAX) ? NSEC_MAX : nsec;
            end
            OP_PAUSE:  stream_paused = 1'b1;
            OP_RESUME: stream_paused = 1'b0;
            default: ;
        endcase
    endtask

    // Random word: mostly well-formed samples moving forward, with the odd
    // jump, step back, bad nanoseconds field and pause or resume.
    task automatic send_random_word();
        logic [1:0]  op;
        logic [31:0] sec;
        logic [29:0] nsec;
        longint      delta;
        longint      total;
        bit          use_delta;
        int unsigned pick;
        int unsigned span;
        pick = $urandom_range(0, 99);
        if (stream_paused)
            op = (pick < 30) ? OP_RESUME : (pick < 34) ? OP_PAUSE :
                 (pick < 37) ? OP_UNUSED : OP_SAMPLE;
        else
            op = (pick < 2) ? OP_PAUSE : (pick < 4) ? OP_RESUME :
                 (pick < 5) ? OP_UNUSED : OP_SAMPLE;
        sec       = $urandom;
        nsec      = 30'($urandom);
        use_delta = 1'b0;
        delta     = 0;
        if (op == OP_SAMPLE) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                span      = (cfg_max_cycle_ns > 600000000) ? 600000000 : cfg_max_cycle_ns;
                delta     = longint'($urandom_range(0, span * 2 + 10));
                use_delta = 1'b1;
            end else if (pick < 68) begin
                delta     = longint'($urandom_range(0, 999999999));
                use_delta = 1'b1;
            end else if (pick < 78) begin
                delta     = longint'($urandom_range(1, 6)) * NS_ONE_SEC
                          + longint'($urandom_range(0, 999999999));
                use_delta = 1'b1;
            end else if (pick < 83) begin
                nsec = 30'($urandom_range(0, 999999999));
            end else if (pick < 89) begin
                sec  = stream_sec - $urandom_range(0, 3);
                nsec = 30'($urandom_range(0, 999999999));
            end else if (pick < 94) begin
                sec  = stream_sec + $urandom_range(0, 1);
                nsec = 30'($urandom_range(1000000000, 30'h3FFFFFFF));
            end else begin
                // Right on the threshold, just past it, or no time at all.
                delta     = (pick == 99) ? 0 : longint'({32'd0, cfg_max_cycle_ns})
                                              + longint'($urandom_range(0, 1));
                use_delta = 1'b1;
            end
            if (use_delta) begin
                total = longint'({34'd0, stream_nsec}) + delta;
                sec   = stream_sec + 32'(total / NS_ONE_SEC);
                nsec  = 30'(total % NS_ONE_SEC);
            end
        end
        send_word(op, sec, nsec, 1'b0, '0);
    endtask

    task automatic send_random_burst(input int count, input int hold_at);
        for (int i = 0; i < count; i++) begin
            if (i == hold_at)
                hold_request = 1'b1;
            send_random_word();
        end
    endtask

    // Stops offering and waits until every expected word has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index, input logic [31:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge aclk);
        if (index == REG_MAX_CYCLE_NS)
            cfg_max_cycle_ns = data;
        else if (index == REG_MIN_LOG_SEC)
            cfg_min_log_sec = data[15:0];
        config_writes++;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Receiver: random stalls, one long hold-off on request, none at the end.
    initial begin
        forever begin
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_request = 1'b0;
            end else if (no_idle) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge aclk);
                if (!no_idle && !hold_request) begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(1, 19)) @(posedge aclk);
                end
            end
        end
    end

    // Result checker: every word taken is compared with the oldest expectation.
    always @(posedge aclk) begin
        cyc_result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("result word with nothing expected", m_gap_ns, 0);
            end else begin
                want = expected_results.pop_front();
                if (m_underrun !== want.underrun)
                    report_mismatch("underrun", 32'(m_underrun), 32'(want.underrun));
                if (m_logged !== want.logged)
                    report_mismatch("logged", 32'(m_logged), 32'(want.logged));
                if (m_gap_ns !== want.gap_ns)
                    report_mismatch("gap_ns", m_gap_ns, want.gap_ns);
                if (m_underrun_total !== want.underrun_total)
                    report_mismatch("underrun_total", m_underrun_total, want.underrun_total);
                if (m_log_total !== want.log_total)
                    report_mismatch("log_total", m_log_total, want.log_total);
                underruns_seen += int'(m_underrun === 1'b1);
                logs_seen      += int'(m_logged === 1'b1);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d words outstanding",
                     cycle_count, expected_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        // Predictor starts from the reset state.
        cfg_max_cycle_ns = MAX_CYCLE_RESET;
        cfg_min_log_sec  = MIN_LOG_RESET;
        mon_prev_valid   = 1'b0;
        mon_prev_sec     = '0;
        mon_prev_nsec    = '0;
        mon_timer_sec    = {16'd0, MIN_LOG_RESET};
        mon_timer_nsec   = '0;
        mon_underruns    = '0;
        mon_logs         = '0;
        mon_paused       = 1'b0;

        // Directed words under the reset configuration: 20 ms threshold, 60 s interval.
        add_row(OP_SAMPLE, 32'd0, 30'd0, 1'b1, 1'b0, 1'b0, 32'd0, 0, 0);
        add_row(OP_SAMPLE, 32'd0, 30'd10000000, 1'b1, 1'b0, 1'b0, 32'd10000000, 0, 0);
        add_row(OP_SAMPLE, 32'd0, 30'd40000000, 1'b1, 1'b1, 1'b1, 32'd30000000, 1, 1);
        add_row(OP_SAMPLE, 32'd1, 30'd0, 1'b1, 1'b1, 1'b0, 32'd960000000, 2, 1);
        add_row(OP_SAMPLE, 32'd9, 30'd999999999, 1'b1, 1'b1, 1'b0, 32'd4000000000, 3, 1);
        // Nanoseconds field beyond range saturates, so no time passes.
        add_row(OP_SAMPLE, 32'd9, 30'h3FFFFFFF, 1'b1, 1'b0, 1'b0, 32'd0, 3, 1);
        // Stepping back a few seconds.
        add_row(OP_SAMPLE, 32'd5, 30'd0, 1'b0, 1'b0, 1'b0, 32'd0, 0, 0);
        add_row(OP_UNUSED, 32'hFFFFFFFF, 30'h3FFFFFFF, 1'b1, 1'b0, 1'b0, 32'd0, 3, 1);
        add_row(OP_PAUSE, 32'd0, 30'd0, 1'b1, 1'b0, 1'b0, 32'd0, 3, 1);
        add_row(OP_PAUSE, 32'd0, 30'd0, 1'b1, 1'b0, 1'b0, 32'd0, 3, 1);
        add_row(OP_SAMPLE, 32'd100, 30'd0, 1'b1, 1'b0, 1'b0, 32'd0, 3, 1);
        add_row(OP_UNUSED, 32'd0, 30'd0, 1'b1, 1'b0, 1'b0, 32'd0, 3, 1);
        add_row(OP_RESUME, 32'd0, 30'd0, 1'b1, 1'b0, 1'b0, 32'd0, 3, 1);
        add_row(OP_RESUME, 32'hFFFFFFFF, 30'h3FFFFFFF, 1'b1, 1'b0, 1'b0, 32'd0, 3, 1);
        add_row(OP_SAMPLE, 32'd100, 30'd0, 1'b1, 1'b0, 1'b0, 32'd0, 3, 1);
        // The resume preloads the timer, so this underrun logs straight away.
        add_row(OP_SAMPLE, 32'd100, 30'd500000000, 1'b1, 1'b1, 1'b1, 32'd500000000, 4, 2);
        add_row(OP_SAMPLE, 32'hFFFFFFFF, 30'd999999999, 1'b1, 1'b1, 1'b1, 32'd4000000000,
                5, 3);
        // Falling back from the top of the range drives the timer to zero.
        add_row(OP_SAMPLE, 32'd0, 30'd0, 1'b0, 1'b0, 1'b0, 32'd0, 0, 0);
        add_row(OP_SAMPLE, 32'd0, 30'd15000000, 1'b0, 1'b0, 1'b0, 32'd0, 0, 0);
        add_row(OP_SAMPLE, 32'd0, 30'd45000000, 1'b0, 1'b0, 1'b0, 32'd0, 0, 0);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].op, directed_rows[i].sec, directed_rows[i].nsec,
                      directed_rows[i].known, directed_rows[i].want);

        // Reset configuration with random traffic.
        send_random_burst(300, -1);
        drain_results();

        // Lowest settings: every real gap is an underrun and every underrun logs.
        write_register(REG_MAX_CYCLE_NS, 32'd0);
        write_register(REG_MIN_LOG_SEC, 32'd0);
        send_random_burst(300, -1);
        drain_results();

        // Highest settings: no gap can exceed the threshold, so the log timer is never cleared by a log.
        write_register(REG_MAX_CYCLE_NS, 32'd4000000000);
        write_register(REG_MIN_LOG_SEC, 32'd65535);
        send_random_burst(250, -1);
        drain_results();

        // Tight threshold, one second interval, with a long receiver hold-off.
        write_register(REG_MAX_CYCLE_NS, 32'd1000000);
        write_register(REG_MIN_LOG_SEC, {16'hABCD, 16'd1});
        send_random_burst(300, 100);
        drain_results();

        // Random settings; a write to an unused index must change nothing.
        write_register(REG_UNUSED, $urandom);
        write_register(REG_MAX_CYCLE_NS, $urandom_range(0, 32'd4000000000));
        write_register(REG_MIN_LOG_SEC, $urandom);
        send_random_burst(300, -1);
        drain_results();

        // Back to the reset values, with no idling on either side.
        write_register(REG_MAX_CYCLE_NS, MAX_CYCLE_RESET);
        write_register(REG_MIN_LOG_SEC, {16'd0, MIN_LOG_RESET});
        no_idle = 1'b1;
        send_random_burst(480, -1);
        drain_results();

        if (expected_results.size() != 0)
            report_mismatch("words never returned", 0, expected_results.size());

        $display("Sent %0d words over six configuration phases with %0d register writes;",
                 words_sent, config_writes);
        $display("checked %0d result words, %0d underruns of which %0d were logged.",
                 results_seen, underruns_seen, logs_seen);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches found", error_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/cyc_pkg.sv
rtl/cyc_gap_calc.sv
rtl/cyc_state.sv
rtl/cycle_overrun_monitor.sv
rtl/cyc_checker.sv
tb/sv/tb_cycle_overrun_monitor.sv
